FILE: src/bsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsh_pkg;

  localparam int KIND_W        = 2;
  localparam int BIN_SHIFT_W   = 5;
  localparam int SOURCE_MODE_W = 2;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 5;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_COUNT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // counted value source
  localparam logic [SOURCE_MODE_W-1:0] SRC_LEFT = 2'd0;
  localparam logic [SOURCE_MODE_W-1:0] SRC_MID  = 2'd1;
  localparam logic [SOURCE_MODE_W-1:0] SRC_SIDE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BIN_SHIFT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_MODE = 1'd1;

endpackage

`default_nettype wire

FILE: src/bsh_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsh_in_if
  import bsh_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [KIND_W-1:0]             kind;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, kind, left_sample, right_sample, input ready);
  modport sink   (input valid, kind, left_sample, right_sample, output ready);
endinterface

interface bsh_out_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] bin_start;
  logic [COUNT_BITS-1:0]       bin_count;

  modport source (output valid, bin_start, bin_count, input ready);
  modport sink   (input valid, bin_start, bin_count, output ready);
endinterface

`default_nettype wire

FILE: src/binned_sample_histogram.sv
// Histogram of signed audio samples in power-of-two bins. A count request
// picks left, mid floor((l+r)/2) or half side floor((l-r)/2) by source_mode,
// floors it to 2^min(bin_shift,SAMPLE_BITS)-wide bins, bumps the bin counter,
// saturating at all ones. A read request returns the start and count of the
// bin holding left_sample; a clear request zeroes every counter. One request
// is taken per clock: the counters sit in one single-port-write RAM with a
// registered read, and a one-deep forward from the write-back covers a bin
// hit on consecutive cycles. Read results go through an output register; a
// read stalls intake only while that register is full and not taken. After
// reset and after each clear request the RAM is swept to zero, one counter a
// cycle, over all 2^SAMPLE_BITS entries (65536 by default), with no request
// taken; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module binned_sample_histogram
  import bsh_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  bsh_in_if.sink                      in_ch,
  bsh_out_if.source                   out_ch
);

  localparam int START_W = SAMPLE_BITS + 1;

  typedef struct packed {
    logic                    is_read;
    logic [SAMPLE_BITS-1:0]  idx;
    logic [START_W-1:0]      start;
  } s1_t;

  logic [BIN_SHIFT_W-1:0]   bin_shift_r;
  logic [SOURCE_MODE_W-1:0] source_mode_r;

  logic                     clearing_r;
  logic [SAMPLE_BITS-1:0]   sweep_addr_r;

  logic                     s1_valid_r;
  s1_t                      s1_r;
  logic                     wr_valid_r;
  logic [SAMPLE_BITS-1:0]   wr_idx_r;
  logic [COUNT_BITS-1:0]    wr_data_r;

  logic                     out_valid_r;
  logic [START_W-1:0]       out_start_r;
  logic [COUNT_BITS-1:0]    out_count_r;

  logic                     in_accept;
  logic                     is_count;
  logic                     is_read;
  logic                     is_clear;
  logic signed [START_W-1:0]     sum_w;
  logic signed [START_W-1:0]     diff_w;
  logic signed [SAMPLE_BITS-1:0] val_w;
  logic signed [SAMPLE_BITS-1:0] q_w;
  logic [BIN_SHIFT_W-1:0]   k_w;
  logic [START_W-1:0]       start_w;

  logic [COUNT_BITS-1:0]    ram_rd;
  logic [COUNT_BITS-1:0]    cur_w;
  logic [COUNT_BITS-1:0]    inc_w;
  logic                     fwd_hit;
  logic                     s1_write;
  logic                     s1_stall;
  logic                     out_load;
  logic                     ram_we;
  logic [SAMPLE_BITS-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0]    ram_wdata;

  // ---------------- intake and bin index
  assign is_count  = (in_ch.kind == KIND_COUNT);
  assign is_read   = (in_ch.kind == KIND_READ);
  assign is_clear  = (in_ch.kind == KIND_CLEAR);
  assign in_ch.ready = !clearing_r && !s1_stall;
  assign in_accept = in_ch.valid && in_ch.ready;

  assign sum_w  = START_W'(in_ch.left_sample) + START_W'(in_ch.right_sample);
  assign diff_w = START_W'(in_ch.left_sample) - START_W'(in_ch.right_sample);

  always_comb begin
    val_w = in_ch.left_sample;
    if (is_count) begin
      unique case (source_mode_r)
        SRC_MID:  val_w = sum_w[START_W-1:1];
        SRC_SIDE: val_w = diff_w[START_W-1:1];
        default:  val_w = in_ch.left_sample;
      endcase
    end
  end

  assign k_w = (bin_shift_r > BIN_SHIFT_W'(SAMPLE_BITS)) ? BIN_SHIFT_W'(SAMPLE_BITS)
                                                        : bin_shift_r;
  assign q_w     = val_w >>> k_w;
  assign start_w = START_W'(q_w) <<< k_w;

  // ---------------- read-modify-write
  assign fwd_hit  = wr_valid_r && (wr_idx_r == s1_r.idx);
  assign cur_w    = fwd_hit ? wr_data_r : ram_rd;
  assign inc_w    = (&cur_w) ? cur_w : cur_w + 1'b1;
  assign s1_write = s1_valid_r && !s1_r.is_read;
  assign s1_stall = s1_valid_r && s1_r.is_read && out_valid_r && !out_ch.ready;
  assign out_load = s1_valid_r && s1_r.is_read && !s1_stall;

  assign ram_we    = clearing_r || s1_write;
  assign ram_waddr = clearing_r ? sweep_addr_r : s1_r.idx;
  assign ram_wdata = clearing_r ? '0 : inc_w;

  bsh_count_ram #(
    .ADDR_W (SAMPLE_BITS),
    .DATA_W (COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept && (is_count || is_read)),
    .raddr (q_w),
    .rdata (ram_rd)
  );

  // ---------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_shift_r   <= '0;
      source_mode_r <= SRC_LEFT;
      clearing_r    <= 1'b1;
      sweep_addr_r  <= '0;
      s1_valid_r    <= 1'b0;
      wr_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BIN_SHIFT:   bin_shift_r   <= cfg_data[BIN_SHIFT_W-1:0];
          CFG_SOURCE_MODE: source_mode_r <= cfg_data[SOURCE_MODE_W-1:0];
          default: ;
        endcase
      end

      if (clearing_r) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
        if (&sweep_addr_r) begin
          clearing_r <= 1'b0;
        end
      end else if (in_accept && is_clear) begin
        clearing_r   <= 1'b1;
        sweep_addr_r <= '0;
      end

      if (!s1_stall) begin
        s1_valid_r <= in_accept && (is_count || is_read);
        wr_valid_r <= s1_write;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload
  always_ff @(posedge clk) begin
    if (!s1_stall) begin
      s1_r.is_read <= is_read;
      s1_r.idx     <= q_w;
      s1_r.start   <= start_w;
      wr_idx_r     <= s1_r.idx;
      wr_data_r    <= inc_w;
    end
    if (out_load) begin
      out_start_r <= s1_r.start;
      out_count_r <= cur_w;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_start = out_start_r;
  assign out_ch.bin_count = out_count_r;

  // ---------------- checks
  a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_write)
    else $error("counter update during clearing sweep");

  a_sweep_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(clearing_r) |-> (sweep_addr_r == '0))
    else $error("clearing sweep does not start at entry zero");

  a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && clearing_r && $past(clearing_r))
      |-> (sweep_addr_r == SAMPLE_BITS'($past(sweep_addr_r) + 1'b1)))
    else $error("clearing sweep skipped an entry");

  a_no_stale_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> !wr_valid_r)
    else $error("forward path live across a clear");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_stall |=> (s1_valid_r && $stable(s1_r)))
    else $error("stalled read request lost");

endmodule

`default_nettype wire

FILE: src/bsh_count_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bsh_count_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sim/tb_binned_sample_histogram.sv
`timescale 1ns / 1ps

module tb_binned_sample_histogram;
  import bsh_pkg::*;

  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 32;
  localparam int IDLE_PCT      = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 330;
  localparam int RECENT_DEPTH  = 16;
  localparam int MAX_REPORTS   = 10;

  // codes the package leaves unnamed
  localparam logic [KIND_W-1:0]        KIND_SPARE = 2'd3;
  localparam logic [SOURCE_MODE_W-1:0] SRC_SPARE  = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] start;
    logic [COUNT_BITS-1:0]       count;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bsh_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  bsh_out_if #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) out_ch ();

  binned_sample_histogram #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #5 clk = ~clk;

  // histogram shadow and register copies
  logic [COUNT_BITS-1:0]    bin_tally [1 << SAMPLE_BITS];
  logic [BIN_SHIFT_W-1:0]   shift_cfg = '0;
  logic [SOURCE_MODE_W-1:0] mode_cfg  = SRC_LEFT;
  bin_result_t              read_expect [$];
  int                       recent_values [$];

  bit          steady_flow = 1'b0;
  int unsigned cycles_run = 0;
  int          fail_count = 0;
  int          requests_sent = 0;
  int          reads_checked = 0;
  int          reg_writes = 0;
  int          clears_sent = 0;

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
  end

  always @(posedge clk) begin
    out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic void log_failure(string msg);
    if (fail_count < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endfunction

  // Applies one accepted request to the shadow histogram; reads queue a result.
  function automatic void predict_request(logic [KIND_W-1:0] kind,
                                          logic signed [SAMPLE_BITS-1:0] l,
                                          logic signed [SAMPLE_BITS-1:0] r);
    int lv;
    int rv;
    int v;
    int q;
    int k;
    int start_full;
    logic [SAMPLE_BITS-1:0] idx;
    bin_result_t res;
    lv = l;
    rv = r;
    k = (shift_cfg > SAMPLE_BITS) ? SAMPLE_BITS : int'(shift_cfg);
    if (kind == KIND_CLEAR) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      return;
    end
    if (kind == KIND_SPARE)
      return;
    v = lv;
    if (kind == KIND_COUNT) begin
      case (mode_cfg)
        SRC_MID:  v = (lv + rv) >>> 1;
        SRC_SIDE: v = (lv - rv) >>> 1;
        default:  v = lv;
      endcase
    end
    q = v >>> k;
    idx = q[SAMPLE_BITS-1:0];
    if (kind == KIND_COUNT) begin
      if (bin_tally[idx] != '1)
        bin_tally[idx] = bin_tally[idx] + 1'b1;
      recent_values.push_back(v);
      if (recent_values.size() > RECENT_DEPTH)
        void'(recent_values.pop_front());
      return;
    end
    start_full = q <<< k;
    res.start = start_full[SAMPLE_BITS:0];
    res.count = bin_tally[idx];
    read_expect.push_back(res);
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic signed [SAMPLE_BITS-1:0] l,
                              input logic signed [SAMPLE_BITS-1:0] r);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    // ready is stable mid-cycle; the request is taken at the next rising edge
    do @(negedge clk); while (!in_ch.ready);
    predict_request(kind, l, r);
    requests_sent++;
    if (kind == KIND_CLEAR)
      clears_sent++;
    @(posedge clk);
  endtask

  // Holds intake until every read result is back, plus a few cycles for
  // counts still in the write-back path.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (read_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (reg_index == CFG_BIN_SHIFT)
      shift_cfg = data[BIN_SHIFT_W-1:0];
    else
      mode_cfg = data[SOURCE_MODE_W-1:0];
    reg_writes++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int center);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50)
      return SAMPLE_BITS'(center + int'($urandom_range(0, 15)) - 8);
    if (roll < 65) begin
      case ($urandom_range(0, 3))
        0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_BITS'($urandom);
  endfunction

  always @(negedge clk) begin : check_results
    bin_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (read_expect.size() == 0) begin
        log_failure($sformatf("unexpected result start=%0d count=%0d",
                              out_ch.bin_start, out_ch.bin_count));
      end else begin
        want = read_expect.pop_front();
        if (out_ch.bin_start !== want.start)
          log_failure($sformatf("bin_start exp %0d got %0d", want.start, out_ch.bin_start));
        if (out_ch.bin_count !== want.count)
          log_failure($sformatf("bin_count exp %0d got %0d", want.count, out_ch.bin_count));
        reads_checked++;
      end
    end
  end

  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  task automatic test_bin_extremes();
    send_request(KIND_COUNT, S_MIN, SAMPLE_BITS'($urandom));
    send_request(KIND_COUNT, S_MAX, SAMPLE_BITS'($urandom));
    send_request(KIND_COUNT, S_MAX, SAMPLE_BITS'($urandom));  // same bin back to back
    send_request(KIND_READ, S_MAX, SAMPLE_BITS'($urandom));
    send_request(KIND_READ, S_MIN, SAMPLE_BITS'($urandom));
    send_request(KIND_READ, '0, SAMPLE_BITS'($urandom));
  endtask

  task automatic test_source_modes();
    drain_results();
    write_reg(CFG_SOURCE_MODE, CFG_DATA_W'(SRC_MID));
    send_request(KIND_COUNT, S_MAX, S_MAX);
    send_request(KIND_COUNT, S_MIN, S_MIN);
    drain_results();
    write_reg(CFG_SOURCE_MODE, CFG_DATA_W'(SRC_SIDE));
    send_request(KIND_COUNT, S_MAX, S_MIN);
    send_request(KIND_COUNT, S_MIN, S_MAX);
    drain_results();
    write_reg(CFG_SOURCE_MODE, {3'b111, SRC_SPARE});  // unused mode counts left as is
    send_request(KIND_COUNT, '1, 16'sd5);
    // reads ignore the source and the right sample
    send_request(KIND_READ, S_MAX, S_MIN);
    send_request(KIND_READ, S_MIN, S_MAX);
    send_request(KIND_READ, '1, '0);
  endtask

  task automatic test_bin_shift();
    drain_results();
    write_reg(CFG_BIN_SHIFT, CFG_DATA_W'(SAMPLE_BITS));
    // counters from the one-value bins are read back under the wide bins
    send_request(KIND_READ, 16'sd100, SAMPLE_BITS'($urandom));
    send_request(KIND_READ, -16'sd5, SAMPLE_BITS'($urandom));
    drain_results();
    write_reg(CFG_BIN_SHIFT, '1);  // above the sample width, acts as full width
    send_request(KIND_COUNT, 16'sd12345, SAMPLE_BITS'($urandom));
    send_request(KIND_READ, S_MIN, SAMPLE_BITS'($urandom));
    drain_results();
    write_reg(CFG_BIN_SHIFT, 5'd4);
    send_request(KIND_COUNT, -16'sd17, SAMPLE_BITS'($urandom));
    send_request(KIND_READ, -16'sd32, SAMPLE_BITS'($urandom));
  endtask

  task automatic test_spare_kind();
    send_request(KIND_SPARE, -16'sd20, SAMPLE_BITS'($urandom));
    send_request(KIND_READ, -16'sd20, SAMPLE_BITS'($urandom));
  endtask

  task automatic test_clear_all();
    send_request(KIND_CLEAR, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    send_request(KIND_READ, S_MAX, SAMPLE_BITS'($urandom));
  endtask

  task automatic test_random_traffic();
    logic [BIN_SHIFT_W-1:0] shift_pick;
    logic [KIND_W-1:0] kind;
    logic signed [SAMPLE_BITS-1:0] l;
    logic signed [SAMPLE_BITS-1:0] r;
    int center;
    int roll;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       shift_pick = '0;
        1:       shift_pick = BIN_SHIFT_W'(SAMPLE_BITS);
        2:       shift_pick = '1;
        3:       shift_pick = BIN_SHIFT_W'($urandom_range(1, SAMPLE_BITS - 1));
        4:       shift_pick = BIN_SHIFT_W'($urandom_range(SAMPLE_BITS + 1, 30));
        default: shift_pick = BIN_SHIFT_W'($urandom_range(0, 8));
      endcase
      write_reg(CFG_BIN_SHIFT, CFG_DATA_W'(shift_pick));
      write_reg(CFG_SOURCE_MODE, {3'($urandom), SOURCE_MODE_W'(phase % 4)});
      steady_flow = (phase == 2);
      center = int'($urandom_range(0, 65535)) - 32768;
      if (phase == 1 || phase == 4)
        send_request(KIND_CLEAR, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2)
          drain_results();
        roll = $urandom_range(0, 99);
        r = pick_sample(center);
        if (roll < 55) begin
          kind = KIND_COUNT;
          l = pick_sample(center);
        end else if (roll < 95) begin
          kind = KIND_READ;
          if (recent_values.size() != 0 && $urandom_range(0, 99) < 60)
            l = SAMPLE_BITS'(recent_values[$urandom_range(0, recent_values.size() - 1)]);
          else
            l = pick_sample(center);
        end else begin
          kind = KIND_SPARE;
          l = pick_sample(center);
        end
        send_request(kind, l, r);
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d reads outstanding", cycles_run, read_expect.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    foreach (bin_tally[i]) bin_tally[i] = '0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_BIN_SHIFT;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_COUNT;
    in_ch.left_sample  <= '0;
    in_ch.right_sample <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bin_extremes();
    test_source_modes();
    test_bin_shift();
    test_spare_kind();
    test_clear_all();
    test_random_traffic();

    drain_results();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d requests (%0d clears), checked %0d bin reads", requests_sent,
             clears_sent, reads_checked);
    $display("%0d register writes across all sources and bin widths, %0d mismatches",
             reg_writes, fail_count);
    if (fail_count == 0 && read_expect.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
